// ===== rtl/qwt_pkg.sv =====
// Shared types and constants for the quoted word tokenizer.
`default_nettype none

package qwt_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_APPEND    = 2'd0;
    localparam logic [1:0] KIND_CLOSE     = 2'd1;
    localparam logic [1:0] KIND_LINE_DONE = 2'd2;
    localparam logic [1:0] KIND_MORE      = 2'd3;

    // Character codes that steer the parser.
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_BQUOTE  = 8'h60;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Parser state carried from one character to the next.
    typedef struct packed {
        logic in_single;
        logic in_double;
        logic escape_pending;
        logic prev_raw_space;
        logic at_line_start;
        logic word_nonempty;
    } state_t;

    // One result as it is queued for the output port.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/qwt_step.sv =====
// Next-state and result logic for one character or line-end transaction.
`default_nettype none

module qwt_step (
    input  wire qwt_pkg::state_t  cur_state,
    input  wire logic [7:0]       char_code,
    input  wire logic             line_end,
    output qwt_pkg::state_t       next_state,
    output logic [1:0]            res_count,
    output qwt_pkg::result_t      res0,
    output qwt_pkg::result_t      res1
);
    import qwt_pkg::*;

    logic kept_char;

    // Characters that a backslash inside double quotes really escapes.
    assign kept_char = (char_code == CH_DQUOTE) || (char_code == CH_BSLASH) ||
                       (char_code == CH_DOLLAR) || (char_code == CH_BQUOTE);

    // Decide the results and the state update for the current transaction.
    always_comb
    begin
        next_state = cur_state;
        res_count  = 2'd0;
        res0       = '0;
        res1       = '0;

        if (line_end)
        begin
            if (cur_state.escape_pending)
            begin
                res0.kind = KIND_MORE;
                res_count = 2'd1;
            end
            else if (cur_state.in_single || cur_state.in_double)
            begin
                res0.kind       = KIND_APPEND;
                res0.char_value = CH_NEWLINE;
                res1.kind       = KIND_MORE;
                res_count       = 2'd2;
                next_state.word_nonempty = 1'b1;
            end
            else if (cur_state.word_nonempty)
            begin
                res0.kind = KIND_CLOSE;
                res1.kind = KIND_LINE_DONE;
                res_count = 2'd2;
                next_state.word_nonempty = 1'b0;
            end
            else
            begin
                res0.kind = KIND_LINE_DONE;
                res_count = 2'd1;
            end
            next_state.at_line_start  = 1'b1;
            next_state.prev_raw_space = 1'b0;
        end
        else
        begin
            if (cur_state.escape_pending)
            begin
                // Inside double quotes an ordinary character keeps its backslash.
                if (cur_state.in_double && !kept_char && !cur_state.at_line_start)
                begin
                    res0.kind       = KIND_APPEND;
                    res0.char_value = CH_BSLASH;
                    res1.kind       = KIND_APPEND;
                    res1.char_value = char_code;
                    res_count       = 2'd2;
                end
                else
                begin
                    res0.kind       = KIND_APPEND;
                    res0.char_value = char_code;
                    res_count       = 2'd1;
                end
                next_state.escape_pending = 1'b0;
                next_state.word_nonempty  = 1'b1;
            end
            else if (cur_state.in_double)
            begin
                if (char_code == CH_DQUOTE)
                    next_state.in_double = 1'b0;
                else if (char_code == CH_BSLASH)
                    next_state.escape_pending = 1'b1;
                else
                begin
                    res0.kind       = KIND_APPEND;
                    res0.char_value = char_code;
                    res_count       = 2'd1;
                    next_state.word_nonempty = 1'b1;
                end
            end
            else if (cur_state.in_single)
            begin
                if (char_code == CH_SQUOTE)
                    next_state.in_single = 1'b0;
                else
                begin
                    res0.kind       = KIND_APPEND;
                    res0.char_value = char_code;
                    res_count       = 2'd1;
                    next_state.word_nonempty = 1'b1;
                end
            end
            else if ((char_code == CH_SPACE) &&
                     (cur_state.at_line_start || cur_state.prev_raw_space))
            begin
                // Leading or repeated space: nothing to report.
            end
            else if (char_code == CH_DQUOTE)
                next_state.in_double = 1'b1;
            else if (char_code == CH_SQUOTE)
                next_state.in_single = 1'b1;
            else if (char_code == CH_BSLASH)
                next_state.escape_pending = 1'b1;
            else if (char_code == CH_SPACE)
            begin
                res0.kind = KIND_CLOSE;
                res_count = 2'd1;
                next_state.word_nonempty = 1'b0;
            end
            else
            begin
                res0.kind       = KIND_APPEND;
                res0.char_value = char_code;
                res_count       = 2'd1;
                next_state.word_nonempty = 1'b1;
            end
            next_state.at_line_start  = 1'b0;
            next_state.prev_raw_space = (char_code == CH_SPACE);
        end

        // Flag the final result of this transaction.
        if (res_count == 2'd1)
            res0.last = 1'b1;
        if (res_count == 2'd2)
            res1.last = 1'b1;
    end

endmodule

`default_nettype wire

// ===== rtl/qwt_result_fifo.sv =====
// Four-entry queue: up to two results in per cycle, one out unless stalled.
`default_nettype none

module qwt_result_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       push_count,
    input  wire qwt_pkg::result_t push0,
    input  wire qwt_pkg::result_t push1,
    output logic                  room_for_two,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output qwt_pkg::result_t      head
);
    import qwt_pkg::*;

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    // Handshake and occupancy.
    assign out_valid    = (count_reg != 3'd0);
    assign pop          = out_valid && !out_stall;
    assign room_for_two = (count_reg <= 3'd2);
    assign head         = entry_reg[rd_ptr_reg];

    // Pointer and count updates.
    assign wr_ptr_next = wr_ptr_reg + push_count;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push_count} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; the second result goes one slot after the first.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_reg + 2'd1] <= push1;
    end

endmodule

`default_nettype wire

// ===== rtl/quoted_word_tokenizer_unit.sv =====
// Top level of the quoted word tokenizer: input register, parser state and result queue.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------
//  input   | in_valid, in_stall | char_code[7:0], line_end
//  output  | out_valid, out_stall | kind[1:0], char_value[7:0], last
//
// A transaction is captured in the input register and parsed from there once the
// queue has two free slots; its zero, one or two results go to a four-entry queue.
// The single output port drains one result per cycle while out_stall is low, so the
// block takes one transaction per cycle for single-result characters, but not for
// two-result ones. Reset clears the parser state to line start and empties the queue.
// in_stall rises while a captured transaction waits for two free queue slots.
`default_nettype none

module quoted_word_tokenizer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       line_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      char_value,
    output logic            last
);
    import qwt_pkg::*;

    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] in_char_reg;
    logic       in_eol_reg;
    state_t     state_reg;
    state_t     state_next;
    logic [1:0] step_count;
    result_t    step_res0;
    result_t    step_res1;
    logic       room_for_two;
    logic       advance;
    logic       in_accept;
    logic [1:0] push_count;
    result_t    head;

    // Input register control.
    assign advance      = in_full_reg && room_for_two;
    assign in_stall     = in_full_reg && !room_for_two;
    assign in_accept    = in_valid && !in_stall;
    assign in_full_next = in_accept || (in_full_reg && !advance);
    assign push_count   = advance ? step_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_char_reg <= char_code;
            in_eol_reg  <= line_end;
        end
    end

    // Parser state advances when the captured transaction is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{in_single: 1'b0, in_double: 1'b0, escape_pending: 1'b0,
                           prev_raw_space: 1'b0, at_line_start: 1'b1,
                           word_nonempty: 1'b0};
        else if (advance)
            state_reg <= state_next;
    end

    qwt_step u_step (
        .cur_state  (state_reg),
        .char_code  (in_char_reg),
        .line_end   (in_eol_reg),
        .next_state (state_next),
        .res_count  (step_count),
        .res0       (step_res0),
        .res1       (step_res1)
    );

    qwt_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push0        (step_res0),
        .push1        (step_res1),
        .room_for_two (room_for_two),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .head         (head)
    );

    // Output payload.
    assign kind       = head.kind;
    assign char_value = head.char_value;
    assign last       = head.last;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the quoted word tokenizer unit.
`timescale 1ns / 100ps

module tb;

    import qwt_pkg::*;

    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int DRAIN_CYCLES       = 8;
    localparam int HOLDOFF_CYCLES     = 150;
    localparam int HOLDOFF_ITEMS      = 40;
    localparam int RANDOM_LINE_TARGET = 1080;
    localparam int NOISE_ITEMS        = 250;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [7:0] char_code  = 8'h00;
    logic       line_end   = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [1:0] kind;
    logic [7:0] char_value;
    logic       last;

    // Predicted parser state and the tokens still owed by the block.
    state_t  parse_st;
    result_t step_tokens[$];
    result_t expected_tokens[$];

    int unsigned error_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned idle_cycles     = 0;
    int          burst_left      = 0;
    logic        sender_gaps     = 1'b1;
    logic        holdoff_req     = 1'b0;

    quoted_word_tokenizer_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .char_value (char_value),
        .last       (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Queue one predicted token and track whether the current word holds anything.
    function automatic void add_token(input logic [1:0] k, input logic [7:0] ch);
        result_t r;
        r.kind       = k;
        r.char_value = (k == KIND_APPEND) ? ch : 8'h00;
        r.last       = 1'b0;
        step_tokens.insert(step_tokens.size(), r);
        if (k == KIND_APPEND)
            parse_st.word_nonempty = 1'b1;
        else if (k == KIND_CLOSE)
            parse_st.word_nonempty = 1'b0;
    endfunction

    // Advance the predicted parser by one input transaction.
    function automatic void predict_tokens(input logic [7:0] ch, input logic eol);
        result_t r;
        step_tokens.delete();
        if (eol)
        begin
            if (parse_st.escape_pending)
                add_token(KIND_MORE, 8'h00);
            else if (parse_st.in_single || parse_st.in_double)
            begin
                add_token(KIND_APPEND, CH_NEWLINE);
                add_token(KIND_MORE, 8'h00);
            end
            else
            begin
                if (parse_st.word_nonempty)
                    add_token(KIND_CLOSE, 8'h00);
                add_token(KIND_LINE_DONE, 8'h00);
            end
            parse_st.at_line_start  = 1'b1;
            parse_st.prev_raw_space = 1'b0;
        end
        else
        begin
            if (parse_st.escape_pending)
            begin
                // Inside double quotes the backslash survives unless it escapes
                // a special character or starts a continued line.
                if (parse_st.in_double && !parse_st.at_line_start &&
                    !(ch inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_BQUOTE}))
                    add_token(KIND_APPEND, CH_BSLASH);
                add_token(KIND_APPEND, ch);
                parse_st.escape_pending = 1'b0;
            end
            else if (parse_st.in_double)
            begin
                if (ch == CH_DQUOTE)
                    parse_st.in_double = 1'b0;
                else if (ch == CH_BSLASH)
                    parse_st.escape_pending = 1'b1;
                else
                    add_token(KIND_APPEND, ch);
            end
            else if (parse_st.in_single)
            begin
                if (ch == CH_SQUOTE)
                    parse_st.in_single = 1'b0;
                else
                    add_token(KIND_APPEND, ch);
            end
            else if (ch == CH_SPACE && (parse_st.at_line_start || parse_st.prev_raw_space))
            begin
                // Leading or repeated spaces produce nothing.
            end
            else if (ch == CH_DQUOTE)
                parse_st.in_double = 1'b1;
            else if (ch == CH_SQUOTE)
                parse_st.in_single = 1'b1;
            else if (ch == CH_BSLASH)
                parse_st.escape_pending = 1'b1;
            else if (ch == CH_SPACE)
                add_token(KIND_CLOSE, 8'h00);
            else
                add_token(KIND_APPEND, ch);
            parse_st.at_line_start  = 1'b0;
            parse_st.prev_raw_space = (ch == CH_SPACE);
        end

        // Flag the final token of this transaction and hand all of them to the checker.
        if (step_tokens.size() != 0)
        begin
            r = step_tokens.pop_back();
            r.last = 1'b1;
            step_tokens.insert(step_tokens.size(), r);
        end
        foreach (step_tokens[i])
            expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endfunction

    // Observe both channels between clock edges, predict on input and check on output.
    always @(negedge clk)
    begin
        result_t exp_tok;
        if (rst_n)
        begin
            idle_cycles++;
            if (in_valid && !in_stall)
            begin
                predict_tokens(char_code, line_end);
                items_accepted++;
                idle_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                results_checked++;
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected result: kind %0d, char_value 0x%02h, last %0d",
                           kind, char_value, last);
                    error_count++;
                end
                else
                begin
                    exp_tok = expected_tokens.pop_front();
                    if (kind !== exp_tok.kind)
                    begin
                        $error("kind mismatch: expected %0d, actual %0d", exp_tok.kind, kind);
                        error_count++;
                    end
                    if (char_value !== exp_tok.char_value)
                    begin
                        $error("char_value mismatch: expected 0x%02h, actual 0x%02h",
                               exp_tok.char_value, char_value);
                        error_count++;
                    end
                    if (last !== exp_tok.last)
                    begin
                        $error("last mismatch: expected %0d, actual %0d", exp_tok.last, last);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request.
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        mode      = STALL_NONE;
        mode_left = 0;
        forever
        begin
            if (holdoff_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                holdoff_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
                    default:     out_stall <= (mode_left % 4 == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one transaction, idling first when a burst has run out.
    task automatic send_item(input logic [7:0] ch, input logic eol);
        logic taken;
        int   gap;
        if (burst_left <= 0)
        begin
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            repeat (gap)
            begin
                in_valid  <= 1'b0;
                char_code <= 8'($urandom_range(0, 255));
                line_end  <= 1'($urandom_range(0, 1));
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid  <= 1'b1;
        char_code <= ch;
        line_end  <= eol;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Line ends carry a random byte that the block must ignore.
    task automatic send_line_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Stop offering and wait until every predicted token has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // Ordinary word character: no space, quote or backslash.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(8'h21, 8'h7E));
        while (c inside {CH_SPACE, CH_DQUOTE, CH_SQUOTE, CH_BSLASH});
        return c;
    endfunction

    // Character biased toward the ones that steer the parser.
    function automatic logic [7:0] tricky_char();
        case ($urandom_range(0, 10))
            0:       return CH_DQUOTE;
            1:       return CH_SQUOTE;
            2:       return CH_BSLASH;
            3:       return CH_DOLLAR;
            4:       return CH_BQUOTE;
            5:       return CH_SPACE;
            6:       return CH_NEWLINE;
            7:       return 8'h00;
            8:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One well-formed command line built from random words, quotes and escapes.
    task automatic send_random_line();
        logic [7:0] c;
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 5)) send_item(plain_char(), 1'b0);
                3:       repeat ($urandom_range(1, 3)) send_item(CH_SPACE, 1'b0);
                4:
                begin
                    send_item(CH_SQUOTE, 1'b0);
                    repeat ($urandom_range(0, 4))
                    begin
                        if ($urandom_range(0, 9) == 0)
                            send_line_end();
                        else
                        begin
                            do
                                c = tricky_char();
                            while (c == CH_SQUOTE);
                            send_item(c, 1'b0);
                        end
                    end
                    send_item(CH_SQUOTE, 1'b0);
                end
                5, 6:
                begin
                    send_item(CH_DQUOTE, 1'b0);
                    repeat ($urandom_range(0, 5))
                    begin
                        case ($urandom_range(0, 5))
                            0:
                            begin
                                send_item(CH_BSLASH, 1'b0);
                                send_item(tricky_char(), 1'b0);
                            end
                            1:
                            begin
                                // Backslash continuation inside double quotes.
                                send_item(CH_BSLASH, 1'b0);
                                send_line_end();
                                send_item(tricky_char(), 1'b0);
                            end
                            2:       send_line_end();
                            default: send_item(plain_char(), 1'b0);
                        endcase
                    end
                    send_item(CH_DQUOTE, 1'b0);
                end
                7:
                begin
                    send_item(CH_BSLASH, 1'b0);
                    send_item(tricky_char(), 1'b0);
                end
                8:
                begin
                    send_item(CH_BSLASH, 1'b0);
                    send_line_end();
                end
                default: send_item(tricky_char(), 1'b0);
            endcase
        end
        send_line_end();
    endtask

    // Spaces skipped at line start and after a space, extreme bytes, word and line close.
    task automatic test_word_splitting();
        send_item(CH_SPACE, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item("w", 1'b0);
        send_line_end();
        drain_results();
    endtask

    // Empty quoted word closed by a space, line end inside single quotes.
    task automatic test_quoting();
        send_item(CH_DQUOTE, 1'b0);
        send_item(CH_DQUOTE, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_SQUOTE, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_line_end();
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_SQUOTE, 1'b0);
        send_line_end();
        drain_results();
    endtask

    // Backslash rules inside and outside double quotes, escape held over a line end.
    task automatic test_escapes();
        send_item(CH_DQUOTE, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_DOLLAR, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item("a", 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_line_end();
        send_item("b", 1'b0);
        send_item(CH_DQUOTE, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_line_end();
        drain_results();
    endtask

    // Long receiver hold-off while the sender keeps offering without gaps.
    task automatic test_receiver_holdoff();
        int unsigned start;
        start       = items_sent;
        sender_gaps = 1'b0;
        holdoff_req = 1'b1;
        while (items_sent - start < HOLDOFF_ITEMS)
            send_random_line();
        wait (holdoff_req == 1'b0);
        sender_gaps = 1'b1;
        drain_results();
    endtask

    // Well-formed random lines, with stretches of idling and of back-to-back traffic.
    task automatic test_random_lines();
        while (items_sent < RANDOM_LINE_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                sender_gaps = ~sender_gaps;
            send_random_line();
            if ($urandom_range(0, 15) == 0)
                drain_results();
        end
        sender_gaps = 1'b1;
        drain_results();
    endtask

    // Unstructured bytes and line ends.
    task automatic test_random_noise();
        repeat (NOISE_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                send_line_end();
            else if ($urandom_range(0, 1) == 0)
                send_item(tricky_char(), 1'b0);
            else
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        drain_results();
    endtask

    // Reset, run each test in turn, then report.
    initial
    begin
        parse_st = '{in_single: 1'b0, in_double: 1'b0, escape_pending: 1'b0,
                     prev_raw_space: 1'b0, at_line_start: 1'b1, word_nonempty: 1'b0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_word_splitting();
        test_quoting();
        test_escapes();
        test_receiver_holdoff();
        test_random_lines();
        test_random_noise();

        if (expected_tokens.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_tokens.size());
            error_count++;
        end
        $display("Sent %0d characters and line ends, checked %0d tokens.",
                 items_accepted, results_checked);
        $display("Covered quoting, escapes, continued lines, a long hold-off and noise.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qwt_pkg.sv
rtl/qwt_step.sv
rtl/qwt_result_fifo.sv
rtl/quoted_word_tokenizer_unit.sv
verif/tb.sv
